/* rtl/tte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  // Tap counter width: covers a window of up to sixteen taps.
  localparam int unsigned CNT_W = 5;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned BPM_W = 16;
  localparam int unsigned MIN_W = 14;
  localparam int unsigned HELD_W = 4;

  // Dividend is 600e6 * (taps - 1), at most 9e9 for sixteen taps.
  localparam int unsigned NUM_W = 34;
  localparam logic [NUM_W-1:0] TENTHS_PER_US = NUM_W'(600000000);
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPM = 2'd2;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd2000000;
  localparam logic [MIN_W-1:0] MIN_BPM_RST = 14'd200;
  localparam logic [BPM_W-1:0] MAX_BPM_RST = 16'd9990;

  // One classified tap handed from front to back.
  typedef struct packed {
    logic [TIME_W-1:0] span;
    logic [CNT_W-1:0]  taps;
  } tap_job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/tte_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tte_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/tte_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tte_front #(
  parameter int unsigned WINDOW = 9
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [tte_pkg::TIME_W-1:0]   tap_time_us_i,
  input  wire logic [tte_pkg::TIME_W-1:0]   timeout_us_i,
  output logic                              job_push_o,
  output tte_pkg::tap_job_t                 job_o,
  input  wire logic                         job_full_i
);

  localparam int unsigned SW = $clog2(WINDOW);
  localparam int unsigned IW = SW + 2;
  localparam int unsigned CW = tte_pkg::CNT_W;

  logic [SW-1:0] slot_q, slot_d, slot_base, slot_new;
  logic [CW-1:0] cnt_q, cnt_d, cnt_base, cnt_new;
  logic [tte_pkg::TIME_W-1:0] newest_q, gap;
  logic [tte_pkg::TIME_W-1:0] stg_t_q;
  logic [CW-1:0] stg_cnt_q;
  logic stg_vld_q, stg_vld_d;
  logic accept, restart;
  logic [IW-1:0] old_sum;
  logic [SW-1:0] old_idx;
  logic [tte_pkg::TIME_W-1:0] old_time;

  assign full   = stg_vld_q & job_full_i;
  assign accept = push & ~full;

  // History restarts when the gap to the newest held tap exceeds the timeout.
  assign gap     = tap_time_us_i - newest_q;
  assign restart = (cnt_q != '0) && (gap > timeout_us_i);

  always_comb begin
    slot_base = restart ? '0 : slot_q;
    cnt_base  = restart ? '0 : cnt_q;
    slot_new  = (slot_base == SW'(WINDOW - 1)) ? '0 : slot_base + SW'(1);
    cnt_new   = (cnt_base < CW'(WINDOW)) ? cnt_base + CW'(1) : cnt_base;
    // Oldest held slot: (slot_new + WINDOW - cnt_new) mod WINDOW.
    old_sum   = IW'(slot_new) + IW'(WINDOW) - IW'(cnt_new);
    if (old_sum >= IW'(WINDOW)) begin
      old_sum = old_sum - IW'(WINDOW);
    end
    old_idx   = old_sum[SW-1:0];
    slot_d    = accept ? slot_new : slot_q;
    cnt_d     = accept ? cnt_new : cnt_q;
  end

  tte_ram #(
    .WIDTH (tte_pkg::TIME_W),
    .DEPTH (WINDOW)
  ) u_times (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_base),
    .wdata_i (tap_time_us_i),
    .re_i    (accept),
    .raddr_i (old_idx),
    .rdata_o (old_time)
  );

  assign job_push_o = stg_vld_q & ~job_full_i;
  assign job_o.span = stg_t_q - old_time;
  assign job_o.taps = stg_cnt_q;

  always_comb begin
    stg_vld_d = stg_vld_q;
    if (accept) begin
      stg_vld_d = 1'b1;
    end else if (job_push_o) begin
      stg_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      cnt_q     <= '0;
      stg_vld_q <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      cnt_q     <= cnt_d;
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      newest_q  <= tap_time_us_i;
      stg_t_q   <= tap_time_us_i;
      stg_cnt_q <= cnt_new;
    end
  end

  a_accept_stages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> stg_vld_q && (cnt_q != '0) && (stg_cnt_q == cnt_q))
    else $error("accepted tap not staged with its count");

endmodule

`default_nettype wire

/* rtl/tte_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module tte_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  tte_pkg::tap_job_t      data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output tte_pkg::tap_job_t      data_o,
  output logic                   empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);

  tte_pkg::tap_job_t ent_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [FW-1:0] fill_q;
  logic do_push, do_pop;

  assign full_o  = (fill_q == FW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/tte_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tte_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        job_empty_i,
  input  tte_pkg::tap_job_t                job_i,
  output logic                             job_pop_o,
  input  wire logic [tte_pkg::MIN_W-1:0]   min_bpm_tenths_i,
  input  wire logic [tte_pkg::BPM_W-1:0]   max_bpm_tenths_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic      [tte_pkg::BPM_W-1:0]   bpm_tenths_o,
  output logic                             tempo_valid_o,
  output logic      [tte_pkg::HELD_W-1:0]  taps_held_o
);

  localparam int unsigned NW = tte_pkg::NUM_W;
  localparam int unsigned TW = tte_pkg::TIME_W;
  localparam int unsigned CW = tte_pkg::CNT_W;

  tte_pkg::back_state_e state_q, state_d;

  logic [NW-1:0] quo_q, quo_d;
  logic [TW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [tte_pkg::STEP_W-1:0] step_q, step_d;
  logic bypass_q, bypass_d, vld_q, vld_d;
  logic [CW-1:0] taps_q, taps_d;
  logic [TW:0] rem_sh;
  logic fit;

  logic out_vld_q, out_vld_d, load;
  logic [tte_pkg::BPM_W-1:0] bpm_q, bpm_res;
  logic tv_q;
  logic [tte_pkg::HELD_W-1:0] held_q;
  logic [NW-1:0] lo_clamp;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign fit    = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    lo_clamp = (quo_q < NW'(min_bpm_tenths_i)) ? NW'(min_bpm_tenths_i) : quo_q;
    if (bypass_q) begin
      bpm_res = quo_q[tte_pkg::BPM_W-1:0];
    end else if (lo_clamp > NW'(max_bpm_tenths_i)) begin
      bpm_res = max_bpm_tenths_i;
    end else begin
      bpm_res = lo_clamp[tte_pkg::BPM_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    step_d    = step_q;
    bypass_d  = bypass_q;
    vld_d     = vld_q;
    taps_d    = taps_q;
    job_pop_o = 1'b0;
    load      = 1'b0;
    case (state_q)
      tte_pkg::B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          taps_d    = job_i.taps;
          if (job_i.taps < CW'(2)) begin
            quo_d    = '0;
            bypass_d = 1'b1;
            vld_d    = 1'b0;
            state_d  = tte_pkg::B_OUT;
          end else if (job_i.span == '0) begin
            quo_d    = NW'(max_bpm_tenths_i);
            bypass_d = 1'b1;
            vld_d    = 1'b1;
            state_d  = tte_pkg::B_OUT;
          end else begin
            quo_d    = tte_pkg::TENTHS_PER_US * NW'(job_i.taps - CW'(1));
            rem_d    = '0;
            dvs_d    = job_i.span;
            step_d   = '0;
            bypass_d = 1'b0;
            vld_d    = 1'b1;
            state_d  = tte_pkg::B_DIV;
          end
        end
      end
      tte_pkg::B_DIV: begin
        rem_d  = fit ? TW'(rem_sh - {1'b0, dvs_q}) : TW'(rem_sh);
        quo_d  = {quo_q[NW-2:0], fit};
        step_d = step_q + tte_pkg::STEP_W'(1);
        if (step_q == tte_pkg::STEP_W'(tte_pkg::DIV_STEPS - 1)) begin
          state_d = tte_pkg::B_OUT;
        end
      end
      tte_pkg::B_OUT: begin
        if (!out_vld_q || pop) begin
          load    = 1'b1;
          state_d = tte_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = tte_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tte_pkg::B_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    step_q   <= step_d;
    bypass_q <= bypass_d;
    vld_q    <= vld_d;
    taps_q   <= taps_d;
    if (load) begin
      bpm_q  <= bpm_res;
      tv_q   <= vld_q;
      held_q <= tte_pkg::HELD_W'(taps_q);
    end
  end

  assign empty         = ~out_vld_q;
  assign bpm_tenths_o  = bpm_q;
  assign tempo_valid_o = tv_q;
  assign taps_held_o   = held_q;

  a_no_tempo_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !tv_q) |-> (bpm_q == '0))
    else $error("result without tempo carries nonzero bpm");

  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tte_pkg::B_DIV && step_q == tte_pkg::STEP_W'(tte_pkg::DIV_STEPS - 1))
      |=> (state_q == tte_pkg::B_OUT))
    else $error("divider overran its step count");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !pop) |=> (out_vld_q && $stable(bpm_q) && $stable(held_q)))
    else $error("waiting result changed");

endmodule

`default_nettype wire

/* rtl/tap_tempo_estimator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake                   | Payload
// ---------+-----------------------------+--------------------------------------------
// tap in   | push / full, beat on        | tap_time_us_i[31:0]
//          |   push & !full              |
// tempo out| empty / pop, beat on        | bpm_tenths_o[15:0], tempo_valid_o,
//          |   pop & !empty              |   taps_held_o[3:0]
// config   | cfg_we_i, no wait           | cfg_idx_i[1:0], cfg_data_i[31:0]
//
// Flow: the front registers an accepted tap in its staging register and hands
//   it on to the job queue from there; the back pops a job in setup, runs the
//   restoring divider, then clamps and loads the output, taking no new job till
//   done. Taps with fewer than two held or a zero span skip the divider.
// Reset: window counters, queue and output valid clear; tap timestamps are
//   not cleared (only slots written since the last restart are used).
// Stalls: a held result stalls the back and reaches the front only through the
//   job queue; full rises only once the staged tap cannot enter a full job queue.
module tap_tempo_estimator #(
  parameter int unsigned WINDOW = 9
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tap input
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [tte_pkg::TIME_W-1:0]       tap_time_us_i,
  // tempo results
  output logic                                  empty,
  input  wire logic                             pop,
  output logic      [tte_pkg::BPM_W-1:0]        bpm_tenths_o,
  output logic                                  tempo_valid_o,
  output logic      [tte_pkg::HELD_W-1:0]       taps_held_o,
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [tte_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tte_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [tte_pkg::TIME_W-1:0] timeout_q;
  logic [tte_pkg::MIN_W-1:0]  min_bpm_q;
  logic [tte_pkg::BPM_W-1:0]  max_bpm_q;

  // Unknown indexes fall to the default arm and are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tte_pkg::TIMEOUT_RST;
      min_bpm_q <= tte_pkg::MIN_BPM_RST;
      max_bpm_q <= tte_pkg::MAX_BPM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tte_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
        tte_pkg::CFG_MIN_BPM: min_bpm_q <= cfg_data_i[tte_pkg::MIN_W-1:0];
        tte_pkg::CFG_MAX_BPM: max_bpm_q <= cfg_data_i[tte_pkg::BPM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic              job_push, job_full, job_pop, job_empty;
  tte_pkg::tap_job_t job_in, job_out;

  // Front: timeout check, window bookkeeping, oldest-tap lookup, span.
  tte_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .tap_time_us_i (tap_time_us_i),
    .timeout_us_i  (timeout_q),
    .job_push_o    (job_push),
    .job_o         (job_in),
    .job_full_i    (job_full)
  );

  // Two-entry queue decouples window update from the divider.
  tte_fifo #(
    .DEPTH (2)
  ) u_jobs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // Back: sequential divide, clamp, output register.
  tte_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_empty_i      (job_empty),
    .job_i            (job_out),
    .job_pop_o        (job_pop),
    .min_bpm_tenths_i (min_bpm_q),
    .max_bpm_tenths_i (max_bpm_q),
    .empty            (empty),
    .pop              (pop),
    .bpm_tenths_o     (bpm_tenths_o),
    .tempo_valid_o    (tempo_valid_o),
    .taps_held_o      (taps_held_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tte_checker.sv */
`timescale 1ns / 1ps

// Watches the tap, tempo and config channels, keeps its own tap window and
// compares each tempo beat against the oldest prediction.
module tte_checker #(
  parameter int unsigned WIN = 9
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic                             full_i,
  input  logic [tte_pkg::TIME_W-1:0]       tap_time_us_i,
  input  logic                             empty_i,
  input  logic                             pop_i,
  input  logic [tte_pkg::BPM_W-1:0]        bpm_tenths_i,
  input  logic                             tempo_valid_i,
  input  logic [tte_pkg::HELD_W-1:0]       taps_held_i,
  input  logic                             cfg_we_i,
  input  logic [tte_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tte_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  import tte_pkg::*;

  typedef struct packed {
    logic [BPM_W-1:0]  bpm;
    logic              valid;
    logic [HELD_W-1:0] held;
  } tempo_beat_t;

  logic [TIME_W-1:0] tap_log [WIN];
  int unsigned       next_slot;
  int unsigned       held_cnt;
  logic [TIME_W-1:0] timeout_q;
  logic [MIN_W-1:0]  min_bpm_q;
  logic [BPM_W-1:0]  max_bpm_q;
  tempo_beat_t       tempo_fifo [$];
  int                fails = 0;
  int                pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Advances the tap window by one tap and returns the tempo it gives.
  function automatic tempo_beat_t predict_tempo(input logic [TIME_W-1:0] t);
    tempo_beat_t       beat;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] span;
    logic [63:0]       quot;
    beat = '0;
    if (held_cnt > 0) begin
      gap = t - tap_log[(next_slot + WIN - 1) % WIN];
      if (gap > timeout_q) begin
        held_cnt  = 0;
        next_slot = 0;
      end
    end
    tap_log[next_slot] = t;
    next_slot = (next_slot + 1) % WIN;
    if (held_cnt < WIN) held_cnt++;
    if (held_cnt >= 2) begin
      span = t - tap_log[(next_slot + WIN - held_cnt) % WIN];
      if (span == '0) begin
        quot = 64'(max_bpm_q);
      end else begin
        quot = (64'd600000000 * 64'(held_cnt - 1)) / 64'(span);
        // lower clamp first, so max wins when the limits cross
        if (quot < 64'(min_bpm_q)) quot = 64'(min_bpm_q);
        if (quot > 64'(max_bpm_q)) quot = 64'(max_bpm_q);
      end
      beat.bpm   = quot[BPM_W-1:0];
      beat.valid = 1'b1;
    end
    beat.held = HELD_W'(held_cnt);
    return beat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tempo_beat_t got;
    tempo_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WIN; i++) tap_log[i] = '0;
      next_slot = 0;
      held_cnt  = 0;
      timeout_q = TIMEOUT_RST;
      min_bpm_q = MIN_BPM_RST;
      max_bpm_q = MAX_BPM_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT: timeout_q = cfg_data_i[TIME_W-1:0];
          CFG_MIN_BPM: min_bpm_q = cfg_data_i[MIN_W-1:0];
          CFG_MAX_BPM: max_bpm_q = cfg_data_i[BPM_W-1:0];
          default: ;
        endcase
      end
      // result side first: a beat can never come from a tap taken this edge
      if (pop_i && !empty_i) begin
        got = '{bpm: bpm_tenths_i, valid: tempo_valid_i, held: taps_held_i};
        if (tempo_fifo.size() == 0) begin
          $error("tempo beat with nothing expected: bpm_tenths %0d", got.bpm);
          fails++;
        end else begin
          want = tempo_fifo.pop_front();
          pending--;
          if (got.bpm !== want.bpm) begin
            $error("bpm_tenths: expected %0d, got %0d", want.bpm, got.bpm);
            fails++;
          end
          if (got.valid !== want.valid) begin
            $error("tempo_valid: expected %0d, got %0d", want.valid, got.valid);
            fails++;
          end
          if (got.held !== want.held) begin
            $error("taps_held: expected %0d, got %0d", want.held, got.held);
            fails++;
          end
        end
      end
      if (push_i && !full_i) begin
        tempo_fifo = {tempo_fifo, predict_tempo(tap_time_us_i)};
        pending++;
      end
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Top: clock, reset, tap stimulus, result-side stalls, config phases and the
// verdict. All prediction and comparison lives in tte_checker.
module testbench;

  import tte_pkg::*;

  localparam int unsigned WINDOW_TAPS    = 9;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          DRAIN_CYCLES   = 60;
  // Index 3 maps to no register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [TIME_W-1:0]     tap_time = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [BPM_W-1:0]      bpm_tenths;
  logic                  tempo_valid;
  logic [HELD_W-1:0]     taps_held;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;

  // Stimulus bookkeeping: beats left in the current push burst, the timeout
  // now in force, and the running tap clock.
  int                burst_left = 0;
  logic [TIME_W-1:0] timeout_now = TIMEOUT_RST;
  logic [TIME_W-1:0] tap_clock;

  // Receiver stall pattern: a pop probability that changes every stretch.
  int pop_pct = 100;
  int stall_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  tap_tempo_estimator #(
    .WINDOW(WINDOW_TAPS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .tap_time_us_i (tap_time),
    .empty         (empty),
    .pop           (pop),
    .bpm_tenths_o  (bpm_tenths),
    .tempo_valid_o (tempo_valid),
    .taps_held_o   (taps_held),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  tte_checker #(
    .WIN(WINDOW_TAPS)
  ) tempo_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_i        (full),
    .tap_time_us_i (tap_time),
    .empty_i       (empty),
    .pop_i         (pop),
    .bpm_tenths_i  (bpm_tenths),
    .tempo_valid_i (tempo_valid),
    .taps_held_i   (taps_held),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Pop side: long stretches at one duty, from always-ready down to 5%, so
  // the result queue sees both back-pressure and free flow.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(20, 300);
      case ($urandom_range(0, 3))
        0:       pop_pct <= 100;
        1:       pop_pct <= 60;
        2:       pop_pct <= 25;
        default: pop_pct <= 5;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    pop <= ($urandom_range(1, 100) <= pop_pct);
  end

  // Watchdog: any cycle with a beat on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One tap beat. Bursts of random length with random gaps between them;
  // push stays high across back-to-back beats of a burst. The random gaps
  // land on every phase of the divider.
  task automatic send_tap(input logic [TIME_W-1:0] t);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                              : $urandom_range(1, 12);
    end
    push     <= 1'b1;
    tap_time <= t;
    do @(posedge clk); while (full);
    burst_left--;
  endtask

  // Stop pushing and wait until every predicted tempo beat has come out.
  // Each tap gives exactly one beat, so an empty prediction queue means idle.
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Random taps in runs that look like someone tapping a steady beat: a run
  // picks a base interval at or below the timeout, taps jitter around it,
  // and a gap just over the timeout starts the next run. Mixed in: gaps of
  // exactly the timeout, zero gaps, one-over gaps and wild timestamps.
  task automatic tap_runs(input int n_taps);
    logic [63:0] base;
    logic [63:0] lim;
    logic [63:0] gap;
    int          sent;
    int          run_len;
    sent = 0;
    while (sent < n_taps) begin
      lim = (timeout_now < 32'd3000000) ? 64'(timeout_now) : 64'd3000000;
      if ($urandom_range(0, 5) == 0) lim = 64'(timeout_now);
      base = 64'($urandom_range(0, 32'(lim)));
      run_len = $urandom_range(1, 14);
      // restart the history before the run
      tap_clock = tap_clock + 32'(64'(timeout_now) + 1 + $urandom_range(0, 5000));
      for (int k = 0; k < run_len && sent < n_taps; k++) begin
        if (k > 0) begin
          case ($urandom_range(0, 19))
            0: gap = 64'(timeout_now);
            1: gap = 0;
            2: gap = 64'(timeout_now) + 1;
            3: gap = 64'($urandom);
            default: begin
              gap = base + $urandom_range(0, 32'(base / 8)) - base / 16;
              if (gap > 64'(timeout_now)) gap = 64'(timeout_now);
            end
          endcase
          tap_clock = tap_clock + 32'(gap);
        end
        send_tap(tap_clock);
        sent++;
      end
    end
  endtask

  // One config phase: wait for idle, write all registers (unused upper data
  // bits carry junk, which the block must drop), then random taps.
  task automatic run_phase(input logic [TIME_W-1:0] tmo,
                           input logic [MIN_W-1:0]  min_bpm,
                           input logic [BPM_W-1:0]  max_bpm,
                           input bit                poke_unused,
                           input int                n_taps);
    drain();
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_MIN_BPM, {18'($urandom), min_bpm});
    write_reg(CFG_MAX_BPM, {16'($urandom), max_bpm});
    if (poke_unused) write_reg(CFG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    timeout_now = tmo;
    tap_runs(n_taps);
  endtask

  function automatic logic [TIME_W-1:0] pick_timeout();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(1, 64);
      1:       return $urandom_range(100000, 3000000);
      2:       return $urandom;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom_range(1000, 200000);
    endcase
  endfunction

  initial begin
    logic [TIME_W-1:0] t;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed taps under the reset settings (timeout 2 s, clamp 20..999 BPM).
    send_tap(32'd0);          // lone tap: no tempo
    send_tap(32'd0);          // zero span: upper clamp
    send_tap(32'd1);          // 1 us span: far over the upper clamp
    send_tap(32'd2000001);    // gap equal to the timeout: history kept
    send_tap(32'd4000002);    // one over the timeout: history restarts
    // steady 120 BPM across the 2^32 wrap, enough taps to overfill the window
    t = 32'hFFF0_0000;
    repeat (11) begin
      send_tap(t);
      t = t + 32'd500000;
    end
    send_tap(32'hFFFF_FFFF);  // far gap: restart at the top timestamp
    send_tap(32'h0000_0000);  // 1 us later across the wrap

    // Config phases: reset values, the extremes, crossed limits, then random.
    tap_clock = $urandom;
    run_phase(TIMEOUT_RST, MIN_BPM_RST, MAX_BPM_RST, 1'b0, 170);
    run_phase(32'd1, 14'd1, 16'd65535, 1'b0, 170);
    run_phase(32'hFFFF_FFFF, 14'd9990, 16'd65535, 1'b0, 170);
    run_phase(32'd2000000, 14'd9990, 16'd100, 1'b1, 170);   // min above max
    run_phase(32'd64, 14'd1, 16'd1, 1'b0, 170);
    repeat (4) begin
      run_phase(pick_timeout(), 14'($urandom_range(1, 9990)),
                16'($urandom_range(1, 65535)), 1'($urandom), 170);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
